[design/gate_index_lifter_assert.svh]
// Assertion macros shared by the gate index lifter RTL
`ifndef GATE_INDEX_LIFTER_ASSERT_SVH
`define GATE_INDEX_LIFTER_ASSERT_SVH

// Condition that must hold at every clock edge out of reset
`define GIL_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Same-cycle implication
`define GIL_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

[design/gil_pkg.sv]
// Types and constants of the gate index lifter
package gil_pkg;

    localparam int MAX_GATE_QUBITS = 4;
    localparam int INDEX_BITS      = 31;
    localparam int PATTERN_W       = 30;
    localparam int GSEL_W          = $clog2(MAX_GATE_QUBITS);
    localparam int ADDR_W          = 5;
    localparam int DATA_W          = 32;

    localparam logic [2:0] REG_NUM_QUBITS  = 3'd0;
    localparam logic [2:0] REG_GATE_WIDTH  = 3'd1;
    localparam logic [2:0] REG_GATE_QUBIT0 = 3'd2;
    localparam logic [2:0] REG_GATE_QUBIT1 = 3'd3;
    localparam logic [2:0] REG_GATE_QUBIT2 = 3'd4;
    localparam logic [2:0] REG_GATE_QUBIT3 = 3'd5;

    typedef struct packed {
        logic [3:0]  row_index;
        logic [3:0]  col_index;
        logic [29:0] free_pattern;
        logic [63:0] value_real;
        logic [63:0] value_imag;
    } item_t;

    typedef struct packed {
        logic [30:0] full_row;
        logic [30:0] full_col;
        logic [63:0] value_real_out;
        logic [63:0] value_imag_out;
        logic        config_error;
    } result_t;

endpackage

[design/gate_index_lifter.sv]
// Gate index lifter: top level with register port and three-stage pipeline
//
// Lifts one entry of a k-qubit gate matrix (k up to 4) to its row and column in the
// full 2^n matrix (n up to 31). Qubit q sits at index bit n-1-q, the first listed gate
// qubit takes the gate index MSB, and free_pattern fills the other positions from low
// to high. The complex value passes through untouched. One request is taken per clock
// while result_ready does not hold the pipeline back; each request passes the input
// register, the scatter/deposit stage and the output register in order.
// Per-position slot, select and rank tables are derived from the registers and
// refreshed every clock, so a request accepted at an edge after a register write
// sees the new value. config_error flags k of 0 or above 4, k above n, a gate qubit at
// or above n, or a repeated gate qubit; full_row and full_col are then zero.
module gate_index_lifter
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [gil_pkg::ADDR_W-1:0]   paddr,
    input  logic [gil_pkg::DATA_W-1:0]   pwdata,
    output logic [gil_pkg::DATA_W-1:0]   prdata,
    output logic                         pready,
    input  logic                         item_valid,
    output logic                         item_ready,
    input  gil_pkg::item_t               item,
    output logic                         result_valid,
    input  logic                         result_ready,
    output gil_pkg::result_t             result
);
    import gil_pkg::*;

    // ---------------- configuration registers ----------------
    logic [4:0] num_qubits_reg;
    logic [2:0] gate_width_reg;
    logic [4:0] gate_qubit_reg [MAX_GATE_QUBITS];

    logic       wr_en;
    logic [2:0] reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_sel = paddr[4:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_qubits_reg <= 5'd1;
            gate_width_reg <= 3'd1;
            for (int i = 0; i < MAX_GATE_QUBITS; i++)
            begin
                gate_qubit_reg[i] <= 5'd0;
            end
        end
        else if (wr_en)
        begin
            case (reg_sel)
                REG_NUM_QUBITS:  num_qubits_reg    <= pwdata[4:0];
                REG_GATE_WIDTH:  gate_width_reg    <= pwdata[2:0];
                REG_GATE_QUBIT0: gate_qubit_reg[0] <= pwdata[4:0];
                REG_GATE_QUBIT1: gate_qubit_reg[1] <= pwdata[4:0];
                REG_GATE_QUBIT2: gate_qubit_reg[2] <= pwdata[4:0];
                REG_GATE_QUBIT3: gate_qubit_reg[3] <= pwdata[4:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_sel)
            REG_NUM_QUBITS:  prdata = {27'd0, num_qubits_reg};
            REG_GATE_WIDTH:  prdata = {29'd0, gate_width_reg};
            REG_GATE_QUBIT0: prdata = {27'd0, gate_qubit_reg[0]};
            REG_GATE_QUBIT1: prdata = {27'd0, gate_qubit_reg[1]};
            REG_GATE_QUBIT2: prdata = {27'd0, gate_qubit_reg[2]};
            REG_GATE_QUBIT3: prdata = {27'd0, gate_qubit_reg[3]};
            default:         prdata = '0;
        endcase
    end

    // ---------------- derived per-position tables ----------------
    logic                  bad_reg,     bad_next;
    logic [INDEX_BITS-1:0] slot_reg,    slot_next;
    logic [INDEX_BITS-1:0] free_en_reg, free_en_next;
    logic [GSEL_W-1:0]     gsel_reg  [INDEX_BITS];
    logic [GSEL_W-1:0]     gsel_next [INDEX_BITS];
    logic [4:0]            rank_reg  [INDEX_BITS];
    logic [4:0]            rank_next [INDEX_BITS];

    logic [MAX_GATE_QUBITS-1:0] act;
    logic [4:0]                 qpos [MAX_GATE_QUBITS];
    logic [2:0]                 below_cnt;

    always_comb
    begin
        bad_next = (gate_width_reg == 3'd0)
                || ({29'd0, gate_width_reg} > 32'(MAX_GATE_QUBITS))
                || ({2'd0, gate_width_reg} > num_qubits_reg)
                || ({27'd0, num_qubits_reg} > 32'(INDEX_BITS));
        for (int i = 0; i < MAX_GATE_QUBITS; i++)
        begin
            act[i]  = 3'(i) < gate_width_reg;
            qpos[i] = num_qubits_reg - 5'd1 - gate_qubit_reg[i];
            if (act[i] && (gate_qubit_reg[i] >= num_qubits_reg))
            begin
                bad_next = 1'b1;
            end
            for (int j = 0; j < i; j++)
            begin
                if (act[i] && (gate_qubit_reg[i] == gate_qubit_reg[j]))
                begin
                    bad_next = 1'b1;
                end
            end
        end

        for (int p = 0; p < INDEX_BITS; p++)
        begin
            slot_next[p] = 1'b0;
            gsel_next[p] = '0;
            below_cnt    = 3'd0;
            for (int i = 0; i < MAX_GATE_QUBITS; i++)
            begin
                if (act[i] && (qpos[i] == 5'(p)))
                begin
                    slot_next[p] = 1'b1;
                    // listed qubit i carries gate index bit k-1-i
                    gsel_next[p] = GSEL_W'(gate_width_reg - 3'd1 - 3'(i));
                end
                if (act[i] && (qpos[i] < 5'(p)))
                begin
                    below_cnt = below_cnt + 3'd1;
                end
            end
            rank_next[p]    = 5'(p) - {2'd0, below_cnt};
            free_en_next[p] = (5'(p) < num_qubits_reg) && !slot_next[p]
                           && (rank_next[p] < 5'(PATTERN_W));
        end
    end

    // reset values match the reset configuration (n = 1, k = 1, qubit 0), but for rank, unused as no position is free
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bad_reg     <= 1'b0;
            slot_reg    <= INDEX_BITS'(1);
            free_en_reg <= '0;
            for (int p = 0; p < INDEX_BITS; p++)
            begin
                gsel_reg[p] <= '0;
                rank_reg[p] <= '0;
            end
        end
        else
        begin
            bad_reg     <= bad_next;
            slot_reg    <= slot_next;
            free_en_reg <= free_en_next;
            for (int p = 0; p < INDEX_BITS; p++)
            begin
                gsel_reg[p] <= gsel_next[p];
                rank_reg[p] <= rank_next[p];
            end
        end
    end

    // ---------------- pipeline control ----------------
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg;
    logic s1_free, s2_free, s3_free;

    assign s3_free    = !s3_valid_reg || result_ready;
    assign s2_free    = !s2_valid_reg || s3_free;
    assign s1_free    = !s1_valid_reg || s2_free;
    assign item_ready = s1_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_free)
            begin
                s1_valid_reg <= item_valid;
            end
            if (s2_free)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (s3_free)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
        end
    end

    // ---------------- stage 1: input register ----------------
    item_t s1_item_reg;

    always_ff @(posedge clk)
    begin
        if (s1_free)
        begin
            s1_item_reg <= item;
        end
    end

    // ---------------- stage 2: scatter gate bits, deposit free bits ----------------
    logic [31:0]           free_pad;
    logic [INDEX_BITS-1:0] row_scat_next, col_scat_next, expand_next;
    logic [INDEX_BITS-1:0] s2_row_reg, s2_col_reg, s2_expand_reg;
    logic [63:0]           s2_real_reg, s2_imag_reg;
    logic                  s2_bad_reg;

    assign free_pad = {2'd0, s1_item_reg.free_pattern};

    always_comb
    begin
        for (int p = 0; p < INDEX_BITS; p++)
        begin
            row_scat_next[p] = slot_reg[p] && s1_item_reg.row_index[gsel_reg[p]];
            col_scat_next[p] = slot_reg[p] && s1_item_reg.col_index[gsel_reg[p]];
            expand_next[p]   = free_en_reg[p] && free_pad[rank_reg[p]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_free)
        begin
            s2_row_reg    <= row_scat_next;
            s2_col_reg    <= col_scat_next;
            s2_expand_reg <= expand_next;
            s2_real_reg   <= s1_item_reg.value_real;
            s2_imag_reg   <= s1_item_reg.value_imag;
            s2_bad_reg    <= bad_reg;
        end
    end

    // ---------------- stage 3: merge into output register ----------------
    result_t s3_result_reg, s3_result_next;

    always_comb
    begin
        s3_result_next.full_row       = s2_bad_reg ? '0 : (s2_row_reg | s2_expand_reg);
        s3_result_next.full_col       = s2_bad_reg ? '0 : (s2_col_reg | s2_expand_reg);
        s3_result_next.value_real_out = s2_real_reg;
        s3_result_next.value_imag_out = s2_imag_reg;
        s3_result_next.config_error   = s2_bad_reg;
    end

    always_ff @(posedge clk)
    begin
        if (s3_free)
        begin
            s3_result_reg <= s3_result_next;
        end
    end

    assign result_valid = s3_valid_reg;
    assign result       = s3_result_reg;

    // ---------------- assertions ----------------
`include "gate_index_lifter_assert.svh"

    `GIL_ASSERT_ALWAYS(a_slot_free_disjoint, (slot_reg & free_en_reg) == '0,
        "slot and free overlap")
    `GIL_ASSERT_ALWAYS(a_slot_count, $countones(slot_reg) <= MAX_GATE_QUBITS,
        "too many gate slots")
    `GIL_ASSERT_IMPLY(a_err_zero, result_valid && result.config_error,
        (result.full_row == '0) && (result.full_col == '0), "error result not zeroed")
    `GIL_ASSERT_IMPLY(a_free_shared, s2_valid_reg && !s2_bad_reg,
        ((s2_row_reg | s2_col_reg) & ~slot_reg) == '0, "gate bits outside slots")

endmodule

[test/gil_index_checker.sv]
// Checker for the gate index lifter: tracks the register file, predicts and compares results
module gil_index_checker
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic                         pready,
    input  logic [gil_pkg::ADDR_W-1:0]   paddr,
    input  logic [gil_pkg::DATA_W-1:0]   pwdata,
    input  logic                         item_valid,
    input  logic                         item_ready,
    input  gil_pkg::item_t               item,
    input  logic                         result_valid,
    input  logic                         result_ready,
    input  gil_pkg::result_t             result,
    output int                           mismatches,
    output int                           outstanding,
    output int                           results_seen,
    output int                           flagged_seen
);
    timeunit 1ns;
    timeprecision 1ps;
    import gil_pkg::*;

    logic [4:0] n_qubits;
    logic [2:0] g_width;
    logic [4:0] g_qubit [MAX_GATE_QUBITS];

    result_t lifted_q [$];

    initial begin
        mismatches   = 0;
        results_seen = 0;
        flagged_seen = 0;
        outstanding  = 0;
    end

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            n_qubits <= 5'd1;
            g_width  <= 3'd1;
            for (int i = 0; i < MAX_GATE_QUBITS; i++)
                g_qubit[i] <= 5'd0;
        end else if (psel && penable && pwrite && pready) begin
            case (paddr[ADDR_W-1:2])
                REG_NUM_QUBITS:  n_qubits   <= pwdata[4:0];
                REG_GATE_WIDTH:  g_width    <= pwdata[2:0];
                REG_GATE_QUBIT0: g_qubit[0] <= pwdata[4:0];
                REG_GATE_QUBIT1: g_qubit[1] <= pwdata[4:0];
                REG_GATE_QUBIT2: g_qubit[2] <= pwdata[4:0];
                REG_GATE_QUBIT3: g_qubit[3] <= pwdata[4:0];
                default: ;
            endcase
        end
    end

    function automatic result_t lift_entry(input item_t it);
        result_t     r;
        logic        bad;
        logic [30:0] slots;
        logic [30:0] spread;
        logic [30:0] row_bits;
        logic [30:0] col_bits;
        int          i;
        int          p;
        int          pos;
        int          sel;
        int          j;
        r        = '0;
        slots    = '0;
        spread   = '0;
        row_bits = '0;
        col_bits = '0;
        bad = (g_width == 0) || (g_width > MAX_GATE_QUBITS) || (g_width > n_qubits)
              || (n_qubits > INDEX_BITS);
        if (!bad) begin
            for (i = 0; i < g_width; i++) begin
                if (g_qubit[i] >= n_qubits)
                    bad = 1'b1;
                for (p = 0; p < i; p++)
                    if (g_qubit[i] == g_qubit[p])
                        bad = 1'b1;
            end
        end
        if (!bad) begin
            // first listed qubit carries the gate index MSB; qubit q lives at bit n-1-q
            for (i = 0; i < g_width; i++) begin
                pos = n_qubits - 1 - g_qubit[i];
                sel = g_width - 1 - i;
                slots[pos]    = 1'b1;
                row_bits[pos] = it.row_index[sel];
                col_bits[pos] = it.col_index[sel];
            end
            j = 0;
            for (p = 0; p < n_qubits; p++) begin
                if (!slots[p]) begin
                    if (j < PATTERN_W)
                        spread[p] = it.free_pattern[j];
                    j++;
                end
            end
            r.full_row = row_bits | spread;
            r.full_col = col_bits | spread;
        end
        r.value_real_out = it.value_real;
        r.value_imag_out = it.value_imag;
        r.config_error   = bad;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected %h, got %h", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk) begin
        result_t want;
        if (rst_n) begin
            // retire before pushing so a same-edge request cannot satisfy itself
            if (result_valid && result_ready) begin
                results_seen++;
                if (result.config_error === 1'b1)
                    flagged_seen++;
                if (lifted_q.size() == 0) begin
                    $error("result arrived with no request outstanding");
                    mismatches++;
                end else begin
                    want = lifted_q.pop_front();
                    check_field("full_row", 64'(want.full_row), 64'(result.full_row));
                    check_field("full_col", 64'(want.full_col), 64'(result.full_col));
                    check_field("value_real_out", want.value_real_out,
                                result.value_real_out);
                    check_field("value_imag_out", want.value_imag_out,
                                result.value_imag_out);
                    check_field("config_error", 64'(want.config_error),
                                64'(result.config_error));
                end
            end
            if (item_valid && item_ready)
                lifted_q.push_back(lift_entry(item));
            outstanding <= lifted_q.size();
        end
    end

endmodule

[test/tb.sv]
// Testbench top for the gate index lifter: clock, reset, stimulus and verdict
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import gil_pkg::*;

    logic                clk          = 1'b0;
    logic                rst_n        = 1'b0;
    logic                psel         = 1'b0;
    logic                penable      = 1'b0;
    logic                pwrite       = 1'b0;
    logic [ADDR_W-1:0]   paddr        = '0;
    logic [DATA_W-1:0]   pwdata       = '0;
    logic [DATA_W-1:0]   prdata;
    logic                pready;
    logic                item_valid   = 1'b0;
    logic                item_ready;
    item_t               item         = '0;
    logic                result_valid;
    logic                result_ready = 1'b0;
    result_t             result;

    int mismatches;
    int outstanding;
    int results_seen;
    int flagged_seen;
    int entries_sent    = 0;
    int settings_loaded = 0;
    int ready_run       = 0;

    gate_index_lifter dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    gil_index_checker index_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .pready       (pready),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .mismatches   (mismatches),
        .outstanding  (outstanding),
        .results_seen (results_seen),
        .flagged_seen (flagged_seen)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    initial begin
        #5_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // receiver: alternating ready/stall runs, now and then a long stall-free stretch
    always @(posedge clk) begin
        if (!rst_n) begin
            result_ready <= 1'b0;
            ready_run    <= 3;
        end else if (ready_run == 0) begin
            result_ready <= ~result_ready;
            if (result_ready)
                ready_run <= $urandom_range(1, 5);
            else if ($urandom_range(0, 7) == 0)
                ready_run <= $urandom_range(60, 150);
            else
                ready_run <= $urandom_range(1, 30);
        end else begin
            ready_run <= ready_run - 1;
        end
    end

    function automatic logic [31:0] reg_word(input logic [31:0] field, input int w);
        // occasionally set bits above the field; the register must ignore them
        if ($urandom_range(0, 3) == 0)
            return field | ($urandom & (32'hFFFF_FFFF << w));
        return field;
    endfunction

    function automatic item_t random_entry();
        item_t it;
        it.row_index = 4'($urandom_range(0, 15));
        it.col_index = 4'($urandom_range(0, 15));
        case ($urandom_range(0, 7))
            0:       it.free_pattern = '0;
            1:       it.free_pattern = '1;
            default: it.free_pattern = 30'($urandom_range(0, 32'h3FFF_FFFF));
        endcase
        it.value_real = {$urandom, $urandom};
        it.value_imag = {$urandom, $urandom};
        return it;
    endfunction

    task automatic wait_drain();
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
    endtask

    task automatic load_config(input logic [4:0] n, input logic [2:0] k,
                               input logic [3:0][4:0] qs);
        item_valid <= 1'b0;
        wait_drain();
        write_reg(REG_NUM_QUBITS,  reg_word(32'(n), 5));
        write_reg(REG_GATE_WIDTH,  reg_word(32'(k), 3));
        write_reg(REG_GATE_QUBIT0, reg_word(32'(qs[0]), 5));
        write_reg(REG_GATE_QUBIT1, reg_word(32'(qs[1]), 5));
        write_reg(REG_GATE_QUBIT2, reg_word(32'(qs[2]), 5));
        write_reg(REG_GATE_QUBIT3, reg_word(32'(qs[3]), 5));
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        settings_loaded++;
    endtask

    task automatic send_item(input item_t it);
        item_valid <= 1'b1;
        item       <= it;
        @(posedge clk);
        while (!item_ready)
            @(posedge clk);
        entries_sent++;
    endtask

    task automatic send_entry(input logic [3:0] r, input logic [3:0] c,
                              input logic [29:0] f, input logic [63:0] vr,
                              input logic [63:0] vi);
        item_t it;
        it.row_index    = r;
        it.col_index    = c;
        it.free_pattern = f;
        it.value_real   = vr;
        it.value_imag   = vi;
        send_item(it);
    endtask

    task automatic pick_valid(output logic [4:0] n, output logic [2:0] k,
                              output logic [3:0][4:0] qs);
        int          kmax;
        int          i;
        logic [31:0] used;
        logic [4:0]  q;
        n    = 5'($urandom_range(1, 31));
        kmax = (n < MAX_GATE_QUBITS) ? int'(n) : MAX_GATE_QUBITS;
        k    = 3'($urandom_range(1, kmax));
        used = '0;
        for (i = 0; i < MAX_GATE_QUBITS; i++) begin
            if (i < k) begin
                do
                    q = 5'($urandom_range(0, n - 1));
                while (used[q]);
                used[q] = 1'b1;
                qs[i]   = q;
            end else begin
                qs[i] = 5'($urandom_range(0, 31));
            end
        end
    endtask

    task automatic pick_invalid(output logic [4:0] n, output logic [2:0] k,
                                output logic [3:0][4:0] qs);
        int i;
        int j;
        pick_valid(n, k, qs);
        case ($urandom_range(0, 4))
            0: k = 3'd0;
            1: k = 3'($urandom_range(5, 7));
            2: begin
                n = 5'($urandom_range(0, 3));
                k = 3'($urandom_range(n + 1, 4));
            end
            3: begin
                i     = $urandom_range(0, k - 1);
                qs[i] = 5'($urandom_range(n, 31));
            end
            default: begin
                // repeated gate qubit
                n = 5'($urandom_range(2, 31));
                k = 3'($urandom_range(2, (n < MAX_GATE_QUBITS) ? int'(n) : MAX_GATE_QUBITS));
                for (i = 0; i < MAX_GATE_QUBITS; i++)
                    qs[i] = 5'($urandom_range(0, n - 1));
                j     = $urandom_range(1, k - 1);
                i     = $urandom_range(0, j - 1);
                qs[j] = qs[i];
            end
        endcase
    endtask

    task automatic run_items(input int count, input bit steady, input bit hold);
        int i;
        int burst;
        burst = $urandom_range(1, 24);
        for (i = 0; i < count; i++) begin
            if (hold && i == count / 2) begin
                item_valid <= 1'b0;
                wait_drain();
            end else if (!steady && burst == 0) begin
                item_valid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge clk);
                burst = $urandom_range(1, 24);
            end
            send_item(random_entry());
            if (burst > 0)
                burst--;
        end
    endtask

    initial begin
        logic [4:0]      n;
        logic [2:0]      k;
        logic [3:0][4:0] qs;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset setting: one qubit, gate on qubit 0; high index and free bits ignored
        send_entry(4'd0, 4'd1, '1, 64'd0, 64'd0);
        send_entry(4'd15, 4'd14, 30'd0, '1, '1);

        // widest circuit, four-qubit gate spread across the index
        load_config(5'd31, 3'd4, {5'd7, 5'd15, 5'd30, 5'd0});
        send_entry(4'd0, 4'd15, 30'd0, '1, 64'd0);
        send_entry(4'd15, 4'd0, '1, 64'd0, '1);
        send_entry(4'd5, 4'd10, 30'h2AAA_AAAA, {2{32'hAAAA_AAAA}}, {2{32'h5555_5555}});
        send_entry(4'd10, 4'd5, 30'h1555_5555, {2{32'h5555_5555}}, {2{32'hAAAA_AAAA}});

        // gate covers every qubit: no free positions
        load_config(5'd4, 3'd4, {5'd0, 5'd1, 5'd2, 5'd3});
        send_entry(4'd9, 4'd6, '1, {$urandom, $urandom}, {$urandom, $urandom});
        send_entry(4'd15, 4'd0, 30'd0, {$urandom, $urandom}, {$urandom, $urandom});

        // single-qubit gate with junk in the unused qubit slots
        load_config(5'd31, 3'd1, {5'd31, 5'd31, 5'd31, 5'd30});
        send_entry(4'd1, 4'd0, '1, {$urandom, $urandom}, {$urandom, $urandom});
        send_entry(4'd14, 4'd15, 30'd0, {$urandom, $urandom}, {$urandom, $urandom});

        // bad settings: zero width, width over four, width over n, qubit out of range,
        // repeated qubit, empty circuit
        load_config(5'd5, 3'd0, {5'd3, 5'd2, 5'd1, 5'd0});
        send_item(random_entry());
        load_config(5'd31, 3'd5, {5'd3, 5'd2, 5'd1, 5'd0});
        send_item(random_entry());
        load_config(5'd31, 3'd7, {5'd3, 5'd2, 5'd1, 5'd0});
        send_item(random_entry());
        load_config(5'd2, 3'd3, {5'd0, 5'd0, 5'd1, 5'd0});
        send_item(random_entry());
        load_config(5'd5, 3'd2, {5'd0, 5'd0, 5'd1, 5'd5});
        send_item(random_entry());
        load_config(5'd8, 3'd3, {5'd0, 5'd1, 5'd4, 5'd1});
        send_item(random_entry());
        load_config(5'd0, 3'd1, {5'd0, 5'd0, 5'd0, 5'd0});
        send_item(random_entry());

        while (entries_sent < 1650) begin
            case ($urandom_range(0, 9))
                0: begin
                    case ($urandom_range(0, 3))
                        0: begin n = 5'd1;  k = 3'd1; qs = {5'd31, 5'd31, 5'd31, 5'd0}; end
                        1: begin n = 5'd31; k = 3'd4; qs = {5'd0, 5'd1, 5'd2, 5'd3}; end
                        2: begin n = 5'd31; k = 3'd4; qs = {5'd27, 5'd28, 5'd29, 5'd30}; end
                        default: begin n = 5'd31; k = 3'd1; qs = {5'd0, 5'd0, 5'd0, 5'd30}; end
                    endcase
                end
                1:       pick_invalid(n, k, qs);
                default: pick_valid(n, k, qs);
            endcase
            load_config(n, k, qs);
            run_items($urandom_range(20, 80), $urandom_range(0, 4) == 0,
                      $urandom_range(0, 3) == 0);
        end

        item_valid <= 1'b0;
        wait_drain();
        repeat (8) @(posedge clk);

        $display("Lifted %0d gate entries under %0d register settings (reset one included).",
                 entries_sent, settings_loaded + 1);
        $display("Checked %0d results, %0d of them flagged config_error; %0d mismatches.",
                 results_seen, flagged_seen, mismatches);
        if (mismatches == 0 && outstanding == 0) begin
            $display("Testbench completed without errors");
        end else begin
            if (outstanding != 0)
                $error("%0d expected results never arrived", outstanding);
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

[gate_index_lifter.f]
+incdir+design
design/gil_pkg.sv
design/gate_index_lifter.sv
test/gil_index_checker.sv
test/tb.sv
